// File: sv/deq_pkg.sv
// Shared types and constants for the double-ended queue core.
// Used by deq_cell and double_ended_queue_core; depends on nothing.
package deq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int MAX_DEPTH     = 1024;
   localparam int DATA_W        = 32;
   localparam int POS_W         = 4;
   localparam int COUNT_W       = 5;
   // wide enough for any fill count up to MAX_DEPTH
   localparam int AT_W          = $clog2(MAX_DEPTH + 1);

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_INSERT     = 3'd4,
      OP_ERASE      = 3'd5,
      OP_READ       = 3'd6,
      OP_CLEAR      = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // Shift command broadcast to every cell of the row
   typedef struct packed {
      logic            open;   // make a gap at 'at' and load the new value there
      logic            close;  // remove the entry at 'at', cells above move down
      logic [AT_W-1:0] at;
   } shift_type;

endpackage

// File: sv/deq_cell.sv
// One storage cell of the queue row: holds one entry and moves it to or
// from its neighbors on a shift command. Depends on deq_pkg.
module deq_cell
   import deq_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic                     clock,
   input  shift_type                shift,
   input  logic signed [DATA_W-1:0] load_value,
   input  logic signed [DATA_W-1:0] prev_value,
   input  logic signed [DATA_W-1:0] next_value,
   output logic signed [DATA_W-1:0] value
);

   localparam logic [AT_W-1:0] IDX = AT_W'(INDEX);

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;

   // next entry: load at the gap, take from below when opening, from above when closing
   always_comb begin
      priority if (shift.open && (IDX == shift.at)) begin
         value_in = load_value;
      end else if (shift.open && (IDX > shift.at)) begin
         value_in = prev_value;
      end else if (shift.close && (IDX >= shift.at)) begin
         value_in = next_value;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// File: sv/double_ended_queue_core.sv
// Double-ended queue core: a row of DEPTH shifting cells plus fill tracking
// and a result register. Depends on deq_pkg and deq_cell.
//
// A request transfer updates the cell row: every cell shifts, loads or holds
// at once, so insert and erase at any position update the row just as pushes
// and pops do. The result register is then loaded from the updated row once
// it is free. A new request is taken on the same edge that loads the previous
// result, so one operation per cycle is sustained while rsp_stall stays low; a
// stalled result holds off the next request. Reset clears the fill count and
// handshake state; entry storage is not cleared and is never read before it
// is written.
module double_ended_queue_core
   import deq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [2:0]                req_op,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [DATA_W-1:0]  req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [DATA_W-1:0]  rsp_read_value,
   output logic signed [DATA_W-1:0]  rsp_front_value,
   output logic signed [DATA_W-1:0]  rsp_back_value,
   output logic [COUNT_W-1:0]        rsp_count,
   output logic                      rsp_is_empty,
   output logic [1:0]                rsp_status
);

   localparam int FW = $clog2(DEPTH + 1);
   localparam logic [FW-1:0] FULL_FILL = FW'(DEPTH);

   // control state
   logic              pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]     fill_ff, fill_in;
   // per-request side info kept for the result cycle
   status_type        status_ff, status_in;
   logic              read_ok_ff, read_ok_in;
   logic [POS_W-1:0]  read_pos_ff;
   // result payload
   logic signed [DATA_W-1:0] rsp_read_ff, rsp_front_ff, rsp_back_ff;
   logic [COUNT_W-1:0]       rsp_count_ff;
   logic                     rsp_empty_ff;
   status_type               rsp_status_ff;

   logic       accept;
   logic       load_rsp;
   op_type     op;
   shift_type  shift;
   logic [AT_W-1:0] fill_x, pos_x;
   logic       full, empty;

   logic signed [DATA_W-1:0] cell_value [DEPTH];
   logic signed [DATA_W-1:0] front_val, back_val, read_val;
   logic [AT_W-1:0]          last_idx;

   // handshake: a pending update moves into the result register when it is free
   assign load_rsp  = pend_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = pend_ff && !load_rsp;
   assign accept    = req_valid && !req_stall;

   // operation decode and fill update
   assign op     = op_type'(req_op);
   assign fill_x = AT_W'(fill_ff);
   assign pos_x  = AT_W'(req_position);
   assign full   = (fill_ff == FULL_FILL);
   assign empty  = (fill_ff == '0);

   always_comb begin
      shift.open  = 1'b0;
      shift.close = 1'b0;
      shift.at    = '0;
      fill_in     = fill_ff;
      status_in   = ST_OK;
      read_ok_in  = 1'b0;
      unique case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               shift.open = 1'b1;
               shift.at   = (op == OP_PUSH_FRONT) ? '0 : fill_x;
               fill_in    = fill_ff + 1'b1;
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               shift.close = (op == OP_POP_FRONT);
               fill_in     = fill_ff - 1'b1;
            end
         end
         OP_INSERT: begin
            if (pos_x > fill_x) begin
               status_in = ST_RANGE;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               shift.open = 1'b1;
               shift.at   = pos_x;
               fill_in    = fill_ff + 1'b1;
            end
         end
         OP_ERASE, OP_READ: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else if (pos_x >= fill_x) begin
               status_in = ST_RANGE;
            end else if (op == OP_ERASE) begin
               shift.close = 1'b1;
               shift.at    = pos_x;
               fill_in     = fill_ff - 1'b1;
            end else begin
               read_ok_in = 1'b1;
            end
         end
         OP_CLEAR: begin
            fill_in = '0;
         end
         default: begin
            fill_in = fill_ff;
         end
      endcase
      // only a transfer moves the row
      if (!accept) begin
         shift.open  = 1'b0;
         shift.close = 1'b0;
      end
   end

   // the cell row
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] prev_v, next_v;
      if (i == 0) begin : g_first
         assign prev_v = '0;
      end else begin : g_mid_prev
         assign prev_v = cell_value[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign next_v = '0;
      end else begin : g_mid_next
         assign next_v = cell_value[i+1];
      end
      deq_cell #(
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .shift      (shift),
         .load_value (req_value),
         .prev_value (prev_v),
         .next_value (next_v),
         .value      (cell_value[i])
      );
   end

   // result values taken from the updated row
   assign last_idx = fill_x - 1'b1;

   always_comb begin
      front_val = '0;
      back_val  = '0;
      read_val  = '0;
      if (!empty) begin
         front_val = cell_value[0];
      end
      for (int i = 0; i < DEPTH; i++) begin
         if (!empty && (AT_W'(i) == last_idx)) begin
            back_val = back_val | cell_value[i];
         end
         if (read_ok_ff && (AT_W'(i) == AT_W'(read_pos_ff))) begin
            read_val = read_val | cell_value[i];
         end
      end
   end

   assign pend_in      = accept ? 1'b1 : (load_rsp ? 1'b0 : pend_ff);
   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fill_ff      <= '0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            fill_ff <= fill_in;
         end
      end
   end

   // request side info and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff   <= status_in;
         read_ok_ff  <= read_ok_in;
         read_pos_ff <= req_position;
      end
      if (load_rsp) begin
         rsp_read_ff   <= read_val;
         rsp_front_ff  <= front_val;
         rsp_back_ff   <= back_val;
         rsp_count_ff  <= COUNT_W'(fill_ff);
         rsp_empty_ff  <= empty;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_read_ff;
   assign rsp_front_value = rsp_front_ff;
   assign rsp_back_value  = rsp_back_ff;
   assign rsp_count       = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_status      = rsp_status_ff;

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_FILL)
      else $error("fill count above depth");

   a_pend_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> pend_ff)
      else $error("transfer did not leave a pending result");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && (status_ff == ST_FULL)) |-> full)
      else $error("full status while queue is not full");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (accept && (op == OP_CLEAR)) |=> (fill_ff == '0))
      else $error("clear left entries behind");

   a_no_accept_blocked: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && !load_rsp) |-> !accept)
      else $error("transfer taken while a result is pending");

endmodule
